[hw/rtl/uartrxf_pkg.sv]
`default_nettype none

package uartrxf_pkg;

  // Default ring size; the ring holds one byte less than this.
  localparam int BUFFER_DEPTH_DEF = 128;

  localparam int BYTE_W     = 8;
  localparam int MARK_W     = 7;
  localparam int EVT_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam int RT_CHARS   = 5;

  // Event kinds carried by one input word.
  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_TX    = 2'd3
  } cmd_t;

  // Software flow control state.
  typedef enum logic [1:0] {
    FLOW_XON_SENT  = 2'd0,
    FLOW_XOFF_SENT = 2'd1,
    FLOW_SEND_XON  = 2'd2,
    FLOW_SEND_XOFF = 2'd3
  } flow_t;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATUS_CHAR      = 3'd0,
    CFG_CYCLE_START_CHAR = 3'd1,
    CFG_FEED_HOLD_CHAR   = 3'd2,
    CFG_SAFETY_DOOR_CHAR = 3'd3,
    CFG_ABORT_CHAR       = 3'd4,
    CFG_FLOW_ENABLE      = 3'd5,
    CFG_LOW_MARK         = 3'd6,
    CFG_FULL_MARK        = 3'd7
  } cfg_idx_t;

  // Realtime event codes.
  localparam logic [EVT_W-1:0] EVT_NONE        = 3'd0;
  localparam logic [EVT_W-1:0] EVT_STATUS      = 3'd1;
  localparam logic [EVT_W-1:0] EVT_CYCLE_START = 3'd2;
  localparam logic [EVT_W-1:0] EVT_FEED_HOLD   = 3'd3;
  localparam logic [EVT_W-1:0] EVT_DOOR        = 3'd4;
  localparam logic [EVT_W-1:0] EVT_ABORT       = 3'd5;

  // Flow control characters.
  localparam logic [BYTE_W-1:0] CHAR_XON  = 8'h11;
  localparam logic [BYTE_W-1:0] CHAR_XOFF = 8'h13;

  // Configuration reset values.
  localparam logic [BYTE_W-1:0] RST_STATUS_CHAR      = 8'd63;
  localparam logic [BYTE_W-1:0] RST_CYCLE_START_CHAR = 8'd126;
  localparam logic [BYTE_W-1:0] RST_FEED_HOLD_CHAR   = 8'd33;
  localparam logic [BYTE_W-1:0] RST_SAFETY_DOOR_CHAR = 8'd64;
  localparam logic [BYTE_W-1:0] RST_ABORT_CHAR       = 8'd24;
  localparam logic [MARK_W-1:0] RST_LOW_MARK         = 7'd64;
  localparam logic [MARK_W-1:0] RST_FULL_MARK        = 7'd96;

  // Controller states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // One result word.
  typedef struct packed {
    logic              read_valid;
    logic [BYTE_W-1:0] read_data;
    logic [EVT_W-1:0]  rt_event;
    logic              overflow;
    logic [MARK_W-1:0] fill_count;
    logic              flow_char_valid;
    logic [BYTE_W-1:0] flow_char;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/uartrxf_in_if.sv]
`default_nettype none

interface uartrxf_in_if;
  import uartrxf_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/uartrxf_out_if.sv]
`default_nettype none

interface uartrxf_out_if;
  import uartrxf_pkg::*;

  logic              valid;
  logic              ready;
  logic              read_valid;
  logic [BYTE_W-1:0] read_data;
  logic [EVT_W-1:0]  rt_event;
  logic              overflow;
  logic [MARK_W-1:0] fill_count;
  logic              flow_char_valid;
  logic [BYTE_W-1:0] flow_char;

  modport source (
    output valid, output read_valid, output read_data, output rt_event,
    output overflow, output fill_count, output flow_char_valid, output flow_char,
    input ready
  );
  modport sink (
    input valid, input read_valid, input read_data, input rt_event,
    input overflow, input fill_count, input flow_char_valid, input flow_char,
    output ready
  );
endinterface

`default_nettype wire

[hw/rtl/uartrxf_ram.sv]
`default_nettype none

module uartrxf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/uartrxf_ctrl.sv]
`default_nettype none

module uartrxf_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire uartrxf_pkg::dp_status_t status,
  output uartrxf_pkg::ctrl_cmd_t      cmd
);
  import uartrxf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a word, then finish it once the result register is free.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.commit = status.out_free;
      end
      default: ;
    endcase
  end

  // A word is finished only from the execute state.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> state_r == S_EXEC)
    else $error("commit outside execute state");

  // A word taken in is always followed by the execute state.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> state_r == S_EXEC)
    else $error("captured word not executed");

  // No new word is taken while one is being executed.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EXEC |-> !in_ready)
    else $error("ready raised during execution");

endmodule

`default_nettype wire

[hw/rtl/uartrxf_dp.sv]
`default_nettype none

module uartrxf_dp #(
  parameter int BUFFER_DEPTH = uartrxf_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire uartrxf_pkg::ctrl_cmd_t              cmd,
  output uartrxf_pkg::dp_status_t                  status,
  input  wire logic [1:0]                          in_cmd,
  input  wire logic [uartrxf_pkg::BYTE_W-1:0]      in_rx_byte,
  input  wire logic                                cfg_we,
  input  wire logic [uartrxf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [uartrxf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output uartrxf_pkg::result_t                     result
);
  import uartrxf_pkg::*;

  localparam int PTR_W  = $clog2(BUFFER_DEPTH);
  localparam int FILL_W = (PTR_W + 1 > MARK_W) ? PTR_W + 1 : MARK_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_V  = (PTR_W + 1)'(BUFFER_DEPTH);

  // Configuration registers.
  logic [BYTE_W-1:0] rt_char_r [RT_CHARS];
  logic              flow_en_r;
  logic [MARK_W-1:0] low_mark_r;
  logic [MARK_W-1:0] full_mark_r;

  // Ring and flow state.
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  flow_t            flow_r, flow_nxt;

  // Held input word.
  cmd_t              cmd_r;
  logic [BYTE_W-1:0] byte_r;

  // Result register.
  logic    out_valid_r;
  result_t res_r, res_nxt;

  logic              ram_we;
  logic [BYTE_W-1:0] ram_rdata;
  logic [PTR_W-1:0]  wr_adv, rd_adv;
  logic [EVT_W-1:0]  rt_evt;
  logic [FILL_W-1:0] fill_after_wr, fill_after_rd, fill_post;

  // Bytes held for a given pair of pointers.
  function automatic logic [FILL_W-1:0] fill_of(input logic [PTR_W-1:0] w,
                                                input logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    d = {1'b0, w} - {1'b0, r};
    if (d[PTR_W]) begin
      d = d + DEPTH_V;
    end
    return FILL_W'(d);
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_char_r[0] <= RST_STATUS_CHAR;
      rt_char_r[1] <= RST_CYCLE_START_CHAR;
      rt_char_r[2] <= RST_FEED_HOLD_CHAR;
      rt_char_r[3] <= RST_SAFETY_DOOR_CHAR;
      rt_char_r[4] <= RST_ABORT_CHAR;
      flow_en_r    <= 1'b0;
      low_mark_r   <= RST_LOW_MARK;
      full_mark_r  <= RST_FULL_MARK;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STATUS_CHAR:      rt_char_r[0] <= cfg_data;
        CFG_CYCLE_START_CHAR: rt_char_r[1] <= cfg_data;
        CFG_FEED_HOLD_CHAR:   rt_char_r[2] <= cfg_data;
        CFG_SAFETY_DOOR_CHAR: rt_char_r[3] <= cfg_data;
        CFG_ABORT_CHAR:       rt_char_r[4] <= cfg_data;
        CFG_FLOW_ENABLE:      flow_en_r    <= cfg_data[0];
        CFG_LOW_MARK:         low_mark_r   <= cfg_data[MARK_W-1:0];
        CFG_FULL_MARK:        full_mark_r  <= cfg_data[MARK_W-1:0];
        default: ;
      endcase
    end
  end

  // Input word holding register.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= cmd_t'(in_cmd);
      byte_r <= in_rx_byte;
    end
  end

  // Byte store: written at the write pointer, read continuously at the read pointer.
  uartrxf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (byte_r),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // Pointer advance with wrap at the ring size.
  assign wr_adv = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_adv = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  assign fill_after_wr = fill_of(wr_adv, rd_ptr_r);
  assign fill_after_rd = fill_of(wr_ptr_r, rd_adv);
  assign fill_post     = fill_of(wr_ptr_nxt, rd_ptr_nxt);

  // Realtime match; the lowest numbered character wins, so it is tested last.
  always_comb begin
    rt_evt = EVT_NONE;
    if (byte_r == rt_char_r[4]) rt_evt = EVT_ABORT;
    if (byte_r == rt_char_r[3]) rt_evt = EVT_DOOR;
    if (byte_r == rt_char_r[2]) rt_evt = EVT_FEED_HOLD;
    if (byte_r == rt_char_r[1]) rt_evt = EVT_CYCLE_START;
    if (byte_r == rt_char_r[0]) rt_evt = EVT_STATUS;
  end

  // Execute the held word.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    flow_nxt   = flow_r;
    ram_we     = 1'b0;
    res_nxt    = '0;
    if (cmd.commit) begin
      case (cmd_r)
        CMD_RX: begin
          if (rt_evt != EVT_NONE) begin
            res_nxt.rt_event = rt_evt;
          end else if (wr_adv != rd_ptr_r) begin
            ram_we     = 1'b1;
            wr_ptr_nxt = wr_adv;
            if (flow_en_r && fill_after_wr >= FILL_W'(full_mark_r) &&
                flow_r == FLOW_XON_SENT) begin
              flow_nxt = FLOW_SEND_XOFF;
            end
          end else begin
            res_nxt.overflow = 1'b1;
          end
        end
        CMD_READ: begin
          if (wr_ptr_r != rd_ptr_r) begin
            res_nxt.read_valid = 1'b1;
            res_nxt.read_data  = ram_rdata;
            rd_ptr_nxt         = rd_adv;
            if (flow_en_r && fill_after_rd < FILL_W'(low_mark_r) &&
                flow_r == FLOW_XOFF_SENT) begin
              flow_nxt = FLOW_SEND_XON;
            end
          end
        end
        CMD_CLEAR: begin
          rd_ptr_nxt = wr_ptr_r;
          flow_nxt   = FLOW_XON_SENT;
        end
        CMD_TX: begin
          if (flow_en_r && flow_r == FLOW_SEND_XOFF) begin
            res_nxt.flow_char_valid = 1'b1;
            res_nxt.flow_char       = CHAR_XOFF;
            flow_nxt                = FLOW_XOFF_SENT;
          end else if (flow_en_r && flow_r == FLOW_SEND_XON) begin
            res_nxt.flow_char_valid = 1'b1;
            res_nxt.flow_char       = CHAR_XON;
            flow_nxt                = FLOW_XON_SENT;
          end
        end
        default: ;
      endcase
      res_nxt.fill_count = fill_post[MARK_W-1:0];
    end
  end

  // Ring pointers and flow state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      flow_r   <= FLOW_XON_SENT;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      flow_r   <= flow_nxt;
    end
  end

  // Result register, held until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign result          = res_r;

  // Pointers stay inside the ring.
  assert property (@(posedge clk) disable iff (!rst_n)
    (PTR_W + 1)'(wr_ptr_r) < DEPTH_V && (PTR_W + 1)'(rd_ptr_r) < DEPTH_V)
    else $error("ring pointer out of range");

  // A finished word always shows a result in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid_r)
    else $error("result lost after commit");

  // A buffer reset leaves the ring empty and the flow state cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && cmd_r == CMD_CLEAR |=> wr_ptr_r == rd_ptr_r && flow_r == FLOW_XON_SENT)
    else $error("buffer reset did not empty the ring");

endmodule

`default_nettype wire

[hw/rtl/uart_rx_fifo_realtime_flow_unit.sv]
// Channel   Direction  Handshake       Payload
// in_ch     in         valid/ready     cmd, rx_byte
// out_ch    out        valid/ready     read_valid, read_data, rt_event, overflow,
//                                      fill_count, flow_char_valid, flow_char
// cfg_*     in         cfg_we only     cfg_index, cfg_data
//
// Each word is taken in by the idle state and executed by the execute state, the
// execute step set by the registered read port of the byte store.
// A new word is taken while the previous result still waits in the output register.
// A stalled output holds the execute step until the result register frees up.
// Reset is synchronous; the byte store itself is not cleared, no pass is needed.
`default_nettype none

module uart_rx_fifo_realtime_flow_unit #(
  parameter int BUFFER_DEPTH = uartrxf_pkg::BUFFER_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  uartrxf_in_if.sink                              in_ch,
  uartrxf_out_if.source                           out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [uartrxf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uartrxf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import uartrxf_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  result_t    result;
  logic       in_ready;
  logic       out_valid;

  // Sequencing of input words.
  uartrxf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .status   (dp_status),
    .cmd      (ctrl_cmd)
  );

  // Ring, realtime matching and flow control.
  uartrxf_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ctrl_cmd),
    .status     (dp_status),
    .in_cmd     (in_ch.cmd),
    .in_rx_byte (in_ch.rx_byte),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .result     (result)
  );

  // Channel connections.
  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid;
  assign out_ch.read_valid      = result.read_valid;
  assign out_ch.read_data       = result.read_data;
  assign out_ch.rt_event        = result.rt_event;
  assign out_ch.overflow        = result.overflow;
  assign out_ch.fill_count      = result.fill_count;
  assign out_ch.flow_char_valid = result.flow_char_valid;
  assign out_ch.flow_char       = result.flow_char;

endmodule

`default_nettype wire

[verif/uartrxf_ring_check.sv]
`default_nettype none

// Watches both channels and the register port, keeps its own copy of the ring,
// the flow control state and the settings, and compares every result word.
module uartrxf_ring_check (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  uartrxf_in_if                                   in_ch,
  uartrxf_out_if                                  out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [uartrxf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [uartrxf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                      errors,
  output int                                      pending
);
  import uartrxf_pkg::*;

  localparam int RING_DEPTH = BUFFER_DEPTH_DEF;

  // Event code for each realtime character slot, lowest slot first.
  localparam logic [EVT_W-1:0] EVT_OF [RT_CHARS] = '{
    EVT_STATUS, EVT_CYCLE_START, EVT_FEED_HOLD, EVT_DOOR, EVT_ABORT
  };

  logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
  int                wr_ptr;
  int                rd_ptr;
  flow_t             flow;
  logic [BYTE_W-1:0] rt_code [RT_CHARS];
  logic              flow_on;
  logic [MARK_W-1:0] xon_mark;
  logic [MARK_W-1:0] xoff_mark;
  result_t           event_results_q [$];
  result_t           want;

  function automatic int wrap_inc(int p);
    return (p == RING_DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic int ring_fill();
    return (wr_ptr - rd_ptr + RING_DEPTH) % RING_DEPTH;
  endfunction

  // Applies one input word to the ring and returns the result word it causes.
  function automatic result_t ring_step(cmd_t op, logic [BYTE_W-1:0] data);
    result_t r;
    int      nxt;
    r = '0;
    case (op)
      CMD_RX: begin
        // Scanning downwards lets the lowest numbered slot win on equal codes.
        for (int k = RT_CHARS - 1; k >= 0; k--)
          if (data == rt_code[k]) r.rt_event = EVT_OF[k];
        if (r.rt_event == EVT_NONE) begin
          nxt = wrap_inc(wr_ptr);
          if (nxt != rd_ptr) begin
            ring_mem[wr_ptr] = data;
            wr_ptr = nxt;
            if (flow_on && ring_fill() >= xoff_mark && flow == FLOW_XON_SENT)
              flow = FLOW_SEND_XOFF;
          end else begin
            r.overflow = 1'b1;
          end
        end
      end
      CMD_READ: begin
        if (wr_ptr != rd_ptr) begin
          r.read_valid = 1'b1;
          r.read_data  = ring_mem[rd_ptr];
          rd_ptr = wrap_inc(rd_ptr);
          if (flow_on && ring_fill() < xon_mark && flow == FLOW_XOFF_SENT)
            flow = FLOW_SEND_XON;
        end
      end
      CMD_CLEAR: begin
        rd_ptr = wr_ptr;
        flow   = FLOW_XON_SENT;
      end
      default: begin
        // A pending character is held back while flow control is off.
        if (flow_on && flow == FLOW_SEND_XOFF) begin
          r.flow_char_valid = 1'b1;
          r.flow_char       = CHAR_XOFF;
          flow = FLOW_XOFF_SENT;
        end else if (flow_on && flow == FLOW_SEND_XON) begin
          r.flow_char_valid = 1'b1;
          r.flow_char       = CHAR_XON;
          flow = FLOW_XON_SENT;
        end
      end
    endcase
    r.fill_count = MARK_W'(ring_fill());
    return r;
  endfunction

  task automatic match_field(string name, int expected, int actual);
    if (expected != actual) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      errors     = 0;
      wr_ptr     = 0;
      rd_ptr     = 0;
      flow       = FLOW_XON_SENT;
      rt_code[0] = RST_STATUS_CHAR;
      rt_code[1] = RST_CYCLE_START_CHAR;
      rt_code[2] = RST_FEED_HOLD_CHAR;
      rt_code[3] = RST_SAFETY_DOOR_CHAR;
      rt_code[4] = RST_ABORT_CHAR;
      flow_on    = 1'b0;
      xon_mark   = RST_LOW_MARK;
      xoff_mark  = RST_FULL_MARK;
      event_results_q.delete();
    end else begin
      // Result words are checked first: one leaving now was accepted earlier.
      if (out_ch.valid && out_ch.ready) begin
        if (event_results_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, expected nothing, actual %h",
                   $time, {out_ch.read_valid, out_ch.read_data, out_ch.rt_event,
                   out_ch.overflow, out_ch.fill_count, out_ch.flow_char_valid,
                   out_ch.flow_char});
        end else begin
          want = event_results_q.pop_front();
          match_field("read_valid", want.read_valid, out_ch.read_valid);
          match_field("read_data", want.read_data, out_ch.read_data);
          match_field("rt_event", want.rt_event, out_ch.rt_event);
          match_field("overflow", want.overflow, out_ch.overflow);
          match_field("fill_count", want.fill_count, out_ch.fill_count);
          match_field("flow_char_valid", want.flow_char_valid, out_ch.flow_char_valid);
          match_field("flow_char", want.flow_char, out_ch.flow_char);
        end
      end

      // Register writes.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_FLOW_ENABLE: flow_on   = cfg_data[0];
          CFG_LOW_MARK:    xon_mark  = cfg_data[MARK_W-1:0];
          CFG_FULL_MARK:   xoff_mark = cfg_data[MARK_W-1:0];
          default:         rt_code[cfg_index] = cfg_data;
        endcase
      end

      // Accepted input word.
      if (in_ch.valid && in_ch.ready)
        event_results_q.push_back(ring_step(cmd_t'(in_ch.cmd), in_ch.rx_byte));
    end
    pending <= event_results_q.size();
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  import uartrxf_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int PHASES          = 12;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    gap_max;
  int                    stall_max;
  int                    stall_left;
  int                    stall_draw;
  int                    quiet_cycles;
  logic [BYTE_W-1:0]     setting [8];

  uartrxf_in_if  in_ch ();
  uartrxf_out_if out_ch ();

  uart_rx_fifo_realtime_flow_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  uartrxf_ring_check i_ring_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: after each word taken, hold ready low for a random number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      stall_draw    = $urandom_range(0, stall_max);
      stall_left   <= stall_draw;
      out_ch.ready <= (stall_draw == 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left   <= 0;
      out_ch.ready <= 1'b1;
    end
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one word after a random gap and returns once it has been taken.
  task automatic send_word(cmd_t op, logic [BYTE_W-1:0] data);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= op;
    in_ch.rx_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops sending and waits until every outstanding result word has come back.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes the whole register set, one register per cycle.
  task automatic program_settings();
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= setting[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Realtime code, biased towards the extremes of the byte range.
  function automatic logic [BYTE_W-1:0] pick_code();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  initial begin
    int                kind;
    int                count;
    int                roll;
    logic [BYTE_W-1:0] shared;
    logic              same_codes;
    cmd_t              op;
    logic [BYTE_W-1:0] data;

    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_RX;
    in_ch.rx_byte <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_STATUS_CHAR;
    cfg_data      <= '0;
    gap_max        = 15;
    stall_max      = 15;
    setting[CFG_STATUS_CHAR]      = RST_STATUS_CHAR;
    setting[CFG_CYCLE_START_CHAR] = RST_CYCLE_START_CHAR;
    setting[CFG_FEED_HOLD_CHAR]   = RST_FEED_HOLD_CHAR;
    setting[CFG_SAFETY_DOOR_CHAR] = RST_SAFETY_DOOR_CHAR;
    setting[CFG_ABORT_CHAR]       = RST_ABORT_CHAR;
    setting[CFG_FLOW_ENABLE]      = 8'd0;
    setting[CFG_LOW_MARK]         = BYTE_W'(RST_LOW_MARK);
    setting[CFG_FULL_MARK]        = BYTE_W'(RST_FULL_MARK);
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: empty reads, idle transmit slot, every realtime code,
    // byte extremes and a buffer reset with data held.
    send_word(CMD_READ, 8'h00);
    send_word(CMD_TX, 8'hFF);
    send_word(CMD_RX, RST_STATUS_CHAR);
    send_word(CMD_RX, RST_CYCLE_START_CHAR);
    send_word(CMD_RX, RST_FEED_HOLD_CHAR);
    send_word(CMD_RX, RST_SAFETY_DOOR_CHAR);
    send_word(CMD_RX, RST_ABORT_CHAR);
    send_word(CMD_RX, 8'h00);
    send_word(CMD_RX, 8'hFF);
    send_word(CMD_READ, 8'hFF);
    send_word(CMD_READ, 8'h00);
    send_word(CMD_READ, 8'h00);
    send_word(CMD_RX, 8'hA5);
    send_word(CMD_CLEAR, 8'h5A);
    send_word(CMD_READ, 8'h00);

    // All realtime codes equal, tight marks: XOFF then XON round trip.
    settle();
    for (int i = 0; i < RT_CHARS; i++) setting[i] = 8'h5A;
    setting[CFG_FLOW_ENABLE] = 8'd1;
    setting[CFG_LOW_MARK]    = 8'd2;
    setting[CFG_FULL_MARK]   = 8'd3;
    program_settings();
    send_word(CMD_RX, 8'h5A);
    send_word(CMD_RX, 8'h01);
    send_word(CMD_RX, 8'h02);
    send_word(CMD_RX, 8'h03);
    send_word(CMD_TX, 8'h00);
    send_word(CMD_TX, 8'h00);
    send_word(CMD_READ, 8'h00);
    send_word(CMD_READ, 8'h00);
    send_word(CMD_TX, 8'h00);

    // A pending XOFF survives a spell with flow control switched off.
    send_word(CMD_RX, 8'h04);
    send_word(CMD_RX, 8'h05);
    settle();
    setting[CFG_FLOW_ENABLE] = 8'd0;
    program_settings();
    send_word(CMD_TX, 8'h00);
    settle();
    setting[CFG_FLOW_ENABLE] = 8'd1;
    program_settings();
    send_word(CMD_TX, 8'h00);
    send_word(CMD_CLEAR, 8'h00);

    // Random phases: fill, drain, balanced and realtime heavy mixes.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      kind      = p % 4;
      gap_max   = (p % 3 == 1) ? 0 : 15;
      stall_max = (p % 3 == 2) ? 0 : 15;
      if (p % 2 == 0) begin
        same_codes = ($urandom_range(0, 3) == 0);
        shared     = pick_code();
        for (int i = 0; i < RT_CHARS; i++) setting[i] = same_codes ? shared : pick_code();
        setting[CFG_FLOW_ENABLE] = (kind == 0) ? 8'd1 : BYTE_W'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: begin
            setting[CFG_LOW_MARK]  = 8'd0;
            setting[CFG_FULL_MARK] = 8'd127;
          end
          1: begin
            setting[CFG_LOW_MARK]  = 8'd127;
            setting[CFG_FULL_MARK] = 8'd0;
          end
          2: begin
            setting[CFG_LOW_MARK]  = BYTE_W'($urandom_range(0, 127));
            setting[CFG_FULL_MARK] = BYTE_W'($urandom_range(0, 127));
          end
          default: begin
            setting[CFG_LOW_MARK]  = BYTE_W'($urandom_range(4, 40));
            setting[CFG_FULL_MARK] = BYTE_W'($urandom_range(60, 120));
          end
        endcase
        program_settings();
      end
      count = (kind == 0) ? 200 : 120;
      repeat (count) begin
        roll = $urandom_range(0, 99);
        case (kind)
          0:       op = (roll < 92) ? CMD_RX : CMD_TX;
          1:       op = (roll < 65) ? CMD_READ : (roll < 85) ? CMD_TX : CMD_RX;
          2:       op = (roll < 40) ? CMD_RX : (roll < 75) ? CMD_READ :
                        (roll < 97) ? CMD_TX : CMD_CLEAR;
          default: op = (roll < 50) ? CMD_RX : (roll < 70) ? CMD_READ :
                        (roll < 90) ? CMD_TX : CMD_CLEAR;
        endcase
        // Some received bytes are taken from the realtime codes in force.
        if ($urandom_range(0, 9) < ((kind == 3) ? 5 : 2))
          data = setting[$urandom_range(0, RT_CHARS - 1)];
        else
          data = BYTE_W'($urandom);
        send_word(op, data);
      end
    end

    // Drain and give the verdict.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/uartrxf_pkg.sv
hw/rtl/uartrxf_in_if.sv
hw/rtl/uartrxf_out_if.sv
hw/rtl/uartrxf_ram.sv
hw/rtl/uartrxf_ctrl.sv
hw/rtl/uartrxf_dp.sv
hw/rtl/uart_rx_fifo_realtime_flow_unit.sv
verif/uartrxf_ring_check.sv
verif/testbench.sv
